>>> hdl/cdrv_pkg.sv
// Package for the degree-based CORDIC rotate/vector unit.
// Holds widths, angle constants, the arctangent table and the FSM state type.
// No dependencies.
package cdrv_pkg;

  localparam int unsigned DataW      = 16;
  localparam int unsigned TableLen   = 14;
  localparam int unsigned Iterations = 14;
  localparam int unsigned IterW      = 4;

  localparam logic signed [DataW-1:0] Deg90  = 16'sd5760;
  localparam logic signed [DataW-1:0] Deg180 = 16'sd11520;
  localparam logic signed [DataW-1:0] Deg270 = 16'sd17280;
  localparam logic signed [DataW-1:0] Deg360 = 16'sd23040;
  localparam logic signed [DataW-1:0] Gain   = 16'sd39;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_SCALE,
    ST_DONE
  } state_e;

  // Arctangent of 2^-n in degrees times 64.
  function automatic logic signed [DataW-1:0] atan_lookup(input logic [IterW-1:0] n);
    logic signed [DataW-1:0] r;
    unique case (n)
      4'd0:    r = 16'sd2880;
      4'd1:    r = 16'sd1700;
      4'd2:    r = 16'sd898;
      4'd3:    r = 16'sd456;
      4'd4:    r = 16'sd229;
      4'd5:    r = 16'sd115;
      4'd6:    r = 16'sd57;
      4'd7:    r = 16'sd29;
      4'd8:    r = 16'sd14;
      4'd9:    r = 16'sd7;
      4'd10:   r = 16'sd4;
      4'd11:   r = 16'sd2;
      4'd12:   r = 16'sd1;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/cdrv_in_if.sv
// Valid/ready channel interfaces for the CORDIC unit.
// Depends on cdrv_pkg.
interface cdrv_in_if;
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [cdrv_pkg::DataW-1:0] x_in;
  logic signed [cdrv_pkg::DataW-1:0] y_in;
  logic signed [cdrv_pkg::DataW-1:0] angle_in;
  modport source (output valid, mode, x_in, y_in, angle_in, input ready);
  modport sink   (input valid, mode, x_in, y_in, angle_in, output ready);
endinterface

interface cdrv_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cdrv_pkg::DataW-1:0] angle_out;
  logic signed [cdrv_pkg::DataW-1:0] magnitude;
  logic signed [cdrv_pkg::DataW-1:0] sine;
  logic signed [cdrv_pkg::DataW-1:0] cosine;
  modport source (output valid, angle_out, magnitude, sine, cosine, input ready);
  modport sink   (input valid, angle_out, magnitude, sine, cosine, output ready);
endinterface

>>> hdl/cdrv_scale.sv
// Bit-serial gain correction: ((x/8)*39)/8 with truncation toward zero.
// Shift-and-add multiply, one multiplier bit per cycle. Depends on cdrv_pkg.
module cdrv_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [cdrv_pkg::DataW-1:0] x_i,
  output logic                              done_o,
  output logic signed [cdrv_pkg::DataW-1:0] mag_o
);
  localparam int unsigned MulBits = 6; // 39 fits in six bits
  localparam int unsigned AccW    = 20;

  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [AccW-1:0] mcand_q, mcand_d;
  logic [MulBits-1:0]     mplier_q, mplier_d;
  logic [2:0]             cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic signed [cdrv_pkg::DataW-1:0] q8;
  logic signed [AccW-1:0] prod;

  // Truncating divide by eight: bias negative values before the shift.
  assign q8 = (x_i + (x_i[cdrv_pkg::DataW-1] ? 16'sd7 : 16'sd0)) >>> 3;

  always_comb begin
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      acc_d    = '0;
      mcand_d  = AccW'(q8);
      mplier_d = MulBits'(cdrv_pkg::Gain);
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_d = acc_q + mcand_q;
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 3'd1;
      if (cnt_q == 3'(MulBits - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = busy_q && (cnt_q == 3'(MulBits - 1)) && !start_i;
  // Last partial product is folded in here so done and the result line up.
  assign prod  = acc_q + (mplier_q[0] ? mcand_q : 20'sd0);
  assign mag_o = cdrv_pkg::DataW'((prod + (prod[AccW-1] ? 20'sd7 : 20'sd0)) >>> 3);
endmodule

>>> hdl/cordic_degree_rotate_vector.sv
// CORDIC unit, degrees*64 angles, 16-bit values with six fraction bits.
// Steps: setup on accept, up to ITERATIONS micro-rotations on one shared
// shift-add datapath, bit-serial gain scaling in vectoring mode, then an
// output state held until out_o.ready; one item is in work at a time.
// Reset (rst_ni low, asynchronous) empties the unit; no result is pending.
module cordic_degree_rotate_vector #(
  parameter int unsigned ITERATIONS = cdrv_pkg::Iterations
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cdrv_in_if.sink      in_i,
  cdrv_out_if.source   out_o
);
  localparam int unsigned W = cdrv_pkg::DataW;

  cdrv_pkg::state_e state_q, state_d;
  logic                        mode_q;
  logic signed [W-1:0]         x_q, y_q, sum_q, ang_q;
  logic [cdrv_pkg::IterW-1:0]  n_q;
  logic                        neg_q;
  logic signed [W-1:0]         x_d, y_d, sum_d;
  logic signed [W-1:0]         res_ang_q, res_mag_q, res_sin_q, res_cos_q;
  logic                        accept, last_iter, ccw, scale_start, scale_done;
  logic signed [W-1:0]         mag_w, a0, a1;
  logic signed [W-1:0]         xs, ys, tab;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == cdrv_pkg::ST_IDLE);
  assign out_o.valid = (state_q == cdrv_pkg::ST_DONE);

  // Shifted operands for the shared micro-rotation.
  assign xs  = x_q >>> n_q;
  assign ys  = y_q >>> n_q;
  assign tab = cdrv_pkg::atan_lookup(n_q);
  // Rotation turns counterclockwise when the sum lags the angle; vectoring
  // drives y toward zero.
  assign ccw = mode_q ? (sum_q < ang_q) : (y_q <= 0);
  assign last_iter = (n_q == cdrv_pkg::IterW'(ITERATIONS - 1));

  // Angle range reduction for rotation mode.
  always_comb begin
    a0 = in_i.angle_in;
    if (in_i.angle_in >= cdrv_pkg::Deg360)       a0 = in_i.angle_in - cdrv_pkg::Deg360;
    else if (in_i.angle_in <= -cdrv_pkg::Deg360) a0 = in_i.angle_in + cdrv_pkg::Deg360;
    a1 = (a0 < 0) ? a0 + cdrv_pkg::Deg360 : a0;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdrv_pkg::ST_IDLE: if (accept) state_d = cdrv_pkg::ST_ITER;
      cdrv_pkg::ST_ITER: begin
        if (!mode_q && y_q == 0) state_d = cdrv_pkg::ST_SCALE;
        else if (last_iter)      state_d = mode_q ? cdrv_pkg::ST_DONE : cdrv_pkg::ST_SCALE;
      end
      cdrv_pkg::ST_SCALE: if (scale_done) state_d = cdrv_pkg::ST_DONE;
      cdrv_pkg::ST_DONE: if (out_o.ready) state_d = cdrv_pkg::ST_IDLE;
      default: state_d = cdrv_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates. The sum follows the turn in rotation mode; in vectoring
  // mode it accumulates the angle taken away from the vector, so its sign flips.
  always_comb begin
    x_d = x_q; y_d = y_q; sum_d = sum_q;
    if (state_q == cdrv_pkg::ST_IDLE && accept) begin
      if (!in_i.mode) begin
        if (in_i.x_in < 0) begin
          x_d = -in_i.x_in; y_d = -in_i.y_in; sum_d = cdrv_pkg::Deg180;
        end else begin
          x_d = in_i.x_in; y_d = in_i.y_in;
          sum_d = (in_i.y_in < 0) ? cdrv_pkg::Deg360 : '0;
        end
      end else begin
        x_d = cdrv_pkg::Gain; y_d = '0;
        sum_d = (a1 > cdrv_pkg::Deg270) ? cdrv_pkg::Deg360 :
                (a1 > cdrv_pkg::Deg90)  ? cdrv_pkg::Deg180 : '0;
      end
    end else if (state_q == cdrv_pkg::ST_ITER && (mode_q || y_q != 0)) begin
      if (ccw) begin
        x_d = x_q - ys; y_d = y_q + xs;
      end else begin
        x_d = x_q + ys; y_d = y_q - xs;
      end
      sum_d = (ccw == mode_q) ? sum_q + tab : sum_q - tab;
    end
  end

  assign scale_start = (state_q == cdrv_pkg::ST_ITER) && (state_d == cdrv_pkg::ST_SCALE);

  cdrv_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .x_i     (x_d),
    .done_o  (scale_done),
    .mag_o   (mag_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdrv_pkg::ST_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == cdrv_pkg::ST_ITER) n_q <= n_q + 1'b1;
      else                              n_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; sum_q <= sum_d;
    if (accept) begin
      mode_q <= in_i.mode;
      ang_q  <= a1;
      neg_q  <= (a1 > cdrv_pkg::Deg90) && (a1 < cdrv_pkg::Deg270);
    end
    if (state_q == cdrv_pkg::ST_ITER && state_d == cdrv_pkg::ST_DONE) begin
      res_ang_q <= '0; res_mag_q <= '0;
      res_sin_q <= neg_q ? -y_d : y_d;
      res_cos_q <= neg_q ? -x_d : x_d;
    end else if (state_q == cdrv_pkg::ST_SCALE && scale_done) begin
      res_ang_q <= sum_q; res_mag_q <= mag_w;
      res_sin_q <= '0;    res_cos_q <= '0;
    end
  end

  assign out_o.angle_out = res_ang_q;
  assign out_o.magnitude = res_mag_q;
  assign out_o.sine      = res_sin_q;
  assign out_o.cosine    = res_cos_q;
endmodule

>>> hdl/cdrv_checker.sv
// Port-level checker for the CORDIC unit, bound to the top level.
// Depends on cdrv_pkg.
module cdrv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [cdrv_pkg::DataW-1:0] out_angle,
  input logic signed [cdrv_pkg::DataW-1:0] out_sine
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("accepted two items");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_angle)) else $error("result dropped");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_angle == 0 || out_sine == 0)) else $error("mode fields mixed");
endmodule

bind cordic_degree_rotate_vector cdrv_checker u_cdrv_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_angle(out_o.angle_out), .out_sine(out_o.sine)
);
